>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; ASSERT_OFF removes every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> hw/rtl/mma_pkg.sv
// types and constants of the matrix multiply-accumulate block
// no dependencies
package mma_pkg;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 6;
  localparam int OPND_W  = 16;
  localparam int ACC_W   = 32;
  localparam int SIZE_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_WR_A    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_C    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_C    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7fff_ffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] inner;
    logic [SIZE_W-1:0] cols;
  } mma_size_t;

  typedef struct packed {
    logic                     wr_a;
    logic                     wr_b;
    logic                     wr_c;
    logic                     rd_c;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [OPND_W-1:0] opnd;
    logic signed [ACC_W-1:0]  accum;
  } mma_host_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } mma_eng_status_t;

endpackage

>>> hw/rtl/mma_if.sv
// request and result channel interfaces of the matrix multiply-accumulate block
// depends on mma_pkg
interface mma_in_if;
  import mma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [OPND_W-1:0] operand_value;
  logic signed [ACC_W-1:0]  accum_value;

  modport source (output valid, cmd, row_index, col_index, operand_value, accum_value,
                  input ready);
  modport sink (input valid, cmd, row_index, col_index, operand_value, accum_value,
                output ready);
endinterface

interface mma_out_if;
  import mma_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] read_value;
  logic                    overflow_seen;
  logic                    bad_index;

  modport source (output valid, read_value, overflow_seen, bad_index, input ready);
  modport sink (input valid, read_value, overflow_seen, bad_index, output ready);
endinterface

>>> hw/rtl/mma_engine.sv
// operand and accumulator memories with the multiply-accumulate sequencer
// depends on mma_pkg and assert_macros.svh
`include "assert_macros.svh"

module mma_engine #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mma_pkg::mma_size_t            size_i,
  input  mma_pkg::mma_host_req_t        host_i,
  input  logic                          start_i,
  output mma_pkg::mma_eng_status_t      status_o,
  output logic signed [mma_pkg::ACC_W-1:0] rd_data_o
);
  import mma_pkg::*;

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW_A = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int AW_B = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int AW_C = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

  logic signed [OPND_W-1:0] a_mem [A_DEPTH];
  logic signed [OPND_W-1:0] b_mem [B_DEPTH];
  logic signed [ACC_W-1:0]  c_mem [C_DEPTH];

  // issue counters
  logic              run_r;
  logic [SIZE_W-1:0] i_r, j_r, k_r;

  // stage 1: memory read data
  logic                     s1_v_r, s1_first_r, s1_last_r, s1_end_r;
  logic [AW_C-1:0]          s1_caddr_r;
  logic signed [OPND_W-1:0] a_rd_r, b_rd_r;
  logic signed [ACC_W-1:0]  c_rd_r;

  // stage 2: product
  logic                    s2_v_r, s2_first_r, s2_last_r, s2_end_r;
  logic [AW_C-1:0]         s2_caddr_r;
  logic signed [ACC_W-1:0] prod_r, cinit_r;

  logic signed [ACC_W-1:0] acc_r;
  logic                    sat_r;

  logic                    tok_first, tok_last, tok_end;
  logic [AW_A-1:0]         a_host_addr, a_rd_addr;
  logic [AW_B-1:0]         b_host_addr, b_rd_addr;
  logic [AW_C-1:0]         c_host_addr, c_cmp_addr, c_rd_addr, c_wr_addr;
  logic                    c_rd_en, c_wr_en;
  logic signed [ACC_W-1:0] c_wr_data;
  logic signed [ACC_W-1:0] prod_nxt, base, acc_nxt;
  logic signed [ACC_W:0]   sum;
  logic                    ovf;

  assign tok_first = (k_r == '0);
  assign tok_last  = (k_r == size_i.inner - SIZE_W'(1));
  assign tok_end   = tok_last && (j_r == size_i.cols - SIZE_W'(1))
                     && (i_r == size_i.rows - SIZE_W'(1));

  assign a_host_addr = AW_A'(host_i.row * MAX_INNER + host_i.col);
  assign b_host_addr = AW_B'(host_i.row * MAX_COLS + host_i.col);
  assign c_host_addr = AW_C'(host_i.row * MAX_COLS + host_i.col);
  assign a_rd_addr   = AW_A'(i_r * MAX_INNER + k_r);
  assign b_rd_addr   = AW_B'(k_r * MAX_COLS + j_r);
  assign c_cmp_addr  = AW_C'(i_r * MAX_COLS + j_r);

  assign c_rd_en   = host_i.rd_c || (run_r && tok_first);
  assign c_rd_addr = host_i.rd_c ? c_host_addr : c_cmp_addr;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      i_r   <= '0;
      j_r   <= '0;
      k_r   <= '0;
    end else if (start_i) begin
      run_r <= 1'b1;
      i_r   <= '0;
      j_r   <= '0;
      k_r   <= '0;
    end else if (run_r) begin
      if (tok_end) begin
        run_r <= 1'b0;
      end else if (tok_last) begin
        k_r <= '0;
        if (j_r == size_i.cols - SIZE_W'(1)) begin
          j_r <= '0;
          i_r <= i_r + SIZE_W'(1);
        end else begin
          j_r <= j_r + SIZE_W'(1);
        end
      end else begin
        k_r <= k_r + SIZE_W'(1);
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (host_i.wr_a) begin
      a_mem[a_host_addr] <= host_i.opnd;
    end
    a_rd_r <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (host_i.wr_b) begin
      b_mem[b_host_addr] <= host_i.opnd;
    end
    b_rd_r <= b_mem[b_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_wr_en) begin
      c_mem[c_wr_addr] <= c_wr_data;
    end
    if (c_rd_en) begin
      c_rd_r <= c_mem[c_rd_addr];
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= run_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= tok_first;
    s1_last_r  <= tok_last;
    s1_end_r   <= tok_end;
    s1_caddr_r <= c_cmp_addr;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_end_r   <= s1_end_r;
    s2_caddr_r <= s1_caddr_r;
    prod_r     <= prod_nxt;
    cinit_r    <= c_rd_r;
  end

  assign prod_nxt = a_rd_r * b_rd_r;

  // saturating accumulate
  always_comb begin
    base = s2_first_r ? cinit_r : acc_r;
    sum  = {base[ACC_W-1], base} + {prod_r[ACC_W-1], prod_r};
    ovf  = (sum[ACC_W] != sum[ACC_W-1]);
    if (!ovf) begin
      acc_nxt = sum[ACC_W-1:0];
    end else if (sum[ACC_W]) begin
      acc_nxt = ACC_MIN;
    end else begin
      acc_nxt = ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (host_i.wr_c) begin
      sat_r <= 1'b0;
    end else if (s2_v_r && ovf) begin
      sat_r <= 1'b1;
    end
  end

  assign c_wr_en   = host_i.wr_c || (s2_v_r && s2_last_r);
  assign c_wr_addr = host_i.wr_c ? c_host_addr : s2_caddr_r;
  assign c_wr_data = host_i.wr_c ? host_i.accum : acc_nxt;

  assign status_o.done = s2_v_r && s2_end_r;
  assign status_o.sat  = sat_r;
  assign rd_data_o     = c_rd_r;

  `ASSERT_NEVER(a_host_while_busy, clk, rst_n,
    (run_r || s1_v_r || s2_v_r) && (host_i.wr_a || host_i.wr_b || host_i.wr_c || host_i.rd_c),
    "host access while the sequencer runs")
  `ASSERT_CLK(a_start_idle, clk, rst_n,
    start_i |-> (!run_r && !s1_v_r && !s2_v_r), "start while the sequencer runs")
  `ASSERT_CLK(a_end_after_issue, clk, rst_n,
    (s2_v_r && s2_end_r) |-> !run_r, "last product while tokens still issue")
endmodule

>>> hw/rtl/matrix_multiply_accumulate.sv
// top level of the matrix multiply-accumulate block: handshake, sizes, result register
// depends on mma_pkg, mma_if, mma_engine and assert_macros.svh
//
//  channel   direction  payload
//  in_req    sink       cmd, row_index, col_index, operand_value, accum_value
//  out_rsp   source     read_value, overflow_seen, bad_index
//  cfg_*     write      cfg_index selects rows, inner or cols; cfg_wdata 7 bit
//
// loads and reads of C take one request per cycle unless the output stalls; a read returns via
// the memory read and result registers; compute holds the channel for rows*inner*cols
// multiply-accumulates, one per cycle from the A/B/C memory ports, plus the pipeline drain
// sync reset: sizes 64 capped at MAX_*, handshake state cleared; memories hold no reset value
// a stalled result waits in the output register while the next request goes on
`include "assert_macros.svh"

module matrix_multiply_accumulate #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mma_pkg::SIZE_W-1:0]        cfg_wdata,
  mma_in_if.sink                            in_req,
  mma_out_if.source                         out_rsp
);
  import mma_pkg::*;

  localparam logic [SIZE_W-1:0] ROWS_CAP  = (MAX_ROWS > 127) ? 7'd127 : SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] INNER_CAP = (MAX_INNER > 127) ? 7'd127 : SIZE_W'(MAX_INNER);
  localparam logic [SIZE_W-1:0] COLS_CAP  = (MAX_COLS > 127) ? 7'd127 : SIZE_W'(MAX_COLS);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > cap) begin
      res = cap;
    end else begin
      res = v;
    end
    return res;
  endfunction

  mma_size_t       size_r;
  mma_host_req_t   host_req;
  mma_eng_status_t eng_status;
  logic signed [ACC_W-1:0] eng_rd_data;

  logic busy_r;
  logic p_v_r, p_bad_r, p_rd_r;
  logic out_v_r, out_ovf_r, out_bad_r;
  logic signed [ACC_W-1:0] out_data_r;

  logic out_free, accept, start;
  logic row_lt_rows, row_lt_inner, col_lt_inner, col_lt_cols;
  logic bad_nxt;

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r.rows  <= clamp_size(SIZE_RESET, ROWS_CAP);
      size_r.inner <= clamp_size(SIZE_RESET, INNER_CAP);
      size_r.cols  <= clamp_size(SIZE_RESET, COLS_CAP);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:  size_r.rows  <= clamp_size(cfg_wdata, ROWS_CAP);
        REG_INNER: size_r.inner <= clamp_size(cfg_wdata, INNER_CAP);
        REG_COLS:  size_r.cols  <= clamp_size(cfg_wdata, COLS_CAP);
        default: ;
      endcase
    end
  end

  assign out_free     = !out_v_r || out_rsp.ready;
  assign in_req.ready = !busy_r && (!p_v_r || out_free);
  assign accept       = in_req.valid && in_req.ready;

  assign row_lt_rows  = {1'b0, in_req.row_index} < size_r.rows;
  assign row_lt_inner = {1'b0, in_req.row_index} < size_r.inner;
  assign col_lt_inner = {1'b0, in_req.col_index} < size_r.inner;
  assign col_lt_cols  = {1'b0, in_req.col_index} < size_r.cols;

  // request decode
  always_comb begin
    host_req.wr_a  = 1'b0;
    host_req.wr_b  = 1'b0;
    host_req.wr_c  = 1'b0;
    host_req.rd_c  = 1'b0;
    host_req.row   = in_req.row_index;
    host_req.col   = in_req.col_index;
    host_req.opnd  = in_req.operand_value;
    host_req.accum = in_req.accum_value;
    start          = 1'b0;
    bad_nxt        = 1'b0;
    case (in_req.cmd)
      CMD_WR_A: begin
        bad_nxt       = !(row_lt_rows && col_lt_inner);
        host_req.wr_a = accept && !bad_nxt;
      end
      CMD_WR_B: begin
        bad_nxt       = !(row_lt_inner && col_lt_cols);
        host_req.wr_b = accept && !bad_nxt;
      end
      CMD_WR_C: begin
        bad_nxt       = !(row_lt_rows && col_lt_cols);
        host_req.wr_c = accept && !bad_nxt;
      end
      CMD_COMPUTE: begin
        start = accept;
      end
      CMD_RD_C: begin
        bad_nxt       = !(row_lt_rows && col_lt_cols);
        host_req.rd_c = accept && !bad_nxt;
      end
      default: ;
    endcase
  end

  mma_engine #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .size_i    (size_r),
    .host_i    (host_req),
    .start_i   (start),
    .status_o  (eng_status),
    .rd_data_o (eng_rd_data)
  );

  // pending result stage, registered alongside the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      p_v_r  <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        p_v_r  <= 1'b0;
      end else if (eng_status.done) begin
        busy_r  <= 1'b0;
        p_v_r   <= 1'b1;
        p_bad_r <= 1'b0;
        p_rd_r  <= 1'b0;
      end else if (accept) begin
        p_v_r   <= 1'b1;
        p_bad_r <= bad_nxt;
        p_rd_r  <= host_req.rd_c;
      end else if (p_v_r && out_free) begin
        p_v_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (p_v_r && out_free) begin
      out_v_r    <= 1'b1;
      out_data_r <= p_rd_r ? eng_rd_data : '0;
      out_ovf_r  <= eng_status.sat;
      out_bad_r  <= p_bad_r;
    end else if (out_rsp.ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_rsp.valid         = out_v_r;
  assign out_rsp.read_value    = out_data_r;
  assign out_rsp.overflow_seen = out_ovf_r;
  assign out_rsp.bad_index     = out_bad_r;

  `ASSERT_CLK(a_done_when_busy, clk, rst_n,
    eng_status.done |-> busy_r, "compute finished while not busy")
  `ASSERT_NEVER(a_busy_no_pending, clk, rst_n,
    busy_r && p_v_r, "pending result during compute")
  `ASSERT_CLK(a_busy_from_compute, clk, rst_n,
    $rose(busy_r) |-> $past(start), "busy without a compute request")
endmodule
